// ===== design/crossfading_wavetable_oscillator_top_macros.svh =====
// ----------------------------------------------------------------------------
// crossfading wavetable oscillator assertion macros
// checks are compiled for simulation only and vanish in synthesis
// ----------------------------------------------------------------------------
`ifndef CROSSFADING_WAVETABLE_OSCILLATOR_TOP_MACROS_SVH
`define CROSSFADING_WAVETABLE_OSCILLATOR_TOP_MACROS_SVH

`ifndef SYNTHESIS

// property that must hold on every clock edge out of reset
`define CWO_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// condition that must hold in the cycle after its trigger
`define CWO_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`else

`define CWO_ASSERT(lbl, clk, rstn, prop, msg)

`define CWO_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

// ===== design/cwo_pkg.sv =====
// ----------------------------------------------------------------------------
// cwo_pkg
// types, opcodes and constants shared by the crossfading wavetable oscillator
// ----------------------------------------------------------------------------
package cwo_pkg;

    // default parameter values
    localparam int TABLE_DEPTH_DEF     = 2048;
    localparam int SAMPLE_BITS_DEF     = 16;
    localparam int PHASE_FRAC_BITS_DEF = 16;

    // fixed field widths
    localparam int OPCODE_BITS = 2;
    localparam int INDEX_BITS  = 11;
    localparam int VALUE_BITS  = 16;
    localparam int OUT_BITS    = 16;

    // configuration port
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 27;
    localparam int STEP_BITS     = 27;
    localparam int REG16_BITS    = 16;

    localparam logic [CFG_IDX_BITS-1:0] CFG_PHASE_STEP  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_VOLUME_GAIN = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_FADE_LENGTH = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_FADE_STEP   = 2'd3;

    localparam logic [STEP_BITS-1:0]  PHASE_STEP_RST  = 27'd0;
    localparam logic [REG16_BITS-1:0] VOLUME_GAIN_RST = 16'd4096;
    localparam logic [REG16_BITS-1:0] FADE_LENGTH_RST = 16'd480;
    localparam logic [REG16_BITS-1:0] FADE_STEP_RST   = 16'd136;

    // opcodes
    localparam logic [OPCODE_BITS-1:0] OP_WRITE  = 2'd0;
    localparam logic [OPCODE_BITS-1:0] OP_COMMIT = 2'd1;
    localparam logic [OPCODE_BITS-1:0] OP_SAMPLE = 2'd2;
    localparam logic [OPCODE_BITS-1:0] OP_NOP    = 2'd3;

    // blend weight is Q1.16, gain is Q4.12
    localparam int BLEND_BITS     = 16;
    localparam int GAIN_FRAC_BITS = 12;
    localparam logic [BLEND_BITS:0] BLEND_ONE = 17'h10000;

    typedef struct packed {
        logic [OPCODE_BITS-1:0]        opcode;
        logic [INDEX_BITS-1:0]         table_index;
        logic signed [VALUE_BITS-1:0]  table_value;
    } req_t;

    typedef struct packed {
        logic signed [OUT_BITS-1:0] sample_out;
        logic                       fading;
    } rsp_t;

endpackage

// ===== design/cwo_ram.sv =====
// ----------------------------------------------------------------------------
// cwo_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module cwo_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/cwo_lerp.sv =====
// ----------------------------------------------------------------------------
// cwo_lerp
// linear blend a + (b - a) * w, w in units of 2^-WEIGHT_BITS, rounded half up
// ----------------------------------------------------------------------------
module cwo_lerp #(
    parameter int SAMPLE_BITS = 16,
    parameter int WEIGHT_BITS = 16
) (
    input  logic signed [SAMPLE_BITS-1:0] a,
    input  logic signed [SAMPLE_BITS-1:0] b,
    input  logic [WEIGHT_BITS:0]          w,
    output logic signed [SAMPLE_BITS-1:0] y
);

    localparam int DW = SAMPLE_BITS + 1;
    localparam int PW = DW + WEIGHT_BITS + 2;
    localparam logic signed [PW-1:0] HALF = PW'(2 ** (WEIGHT_BITS - 1));

    logic signed [DW-1:0]            diff;
    logic signed [WEIGHT_BITS+1:0]   w_s;
    logic signed [PW-1:0]            prod;
    logic signed [PW-1:0]            shifted;
    logic signed [DW-1:0]            sum;

    always_comb
    begin
        diff    = DW'(b) - DW'(a);
        w_s     = $signed({1'b0, w});
        prod    = PW'(diff) * PW'(w_s);
        shifted = (prod + HALF) >>> WEIGHT_BITS;
        // result lies between a and b, so it fits the sample width
        sum     = DW'(a) + DW'(shifted);
        y       = SAMPLE_BITS'(sum);
    end

endmodule

// ===== design/crossfading_wavetable_oscillator_top.sv =====
// ----------------------------------------------------------------------------
// crossfading_wavetable_oscillator_top
// two-table wavetable oscillator with interpolation, crossfade and gain
// ----------------------------------------------------------------------------
// A sample beat moves through S_RB, S_IP, S_BL and S_GN once accepted and
// loads the result register as it leaves S_GN; no new beat is accepted until
// the block is back in S_IDLE. The two wavetables sit in separate rams with one
// read port each. Both neighbors of the phase are fetched by two consecutive
// reads of both rams at once; the first read is issued in the accepting cycle.
// Interpolation, crossfade blend and gain take the states S_IP, S_BL and S_GN
// in turn. If the previous result has not been taken, the gain step waits for
// the output register. Write, commit and no-op beats leave the block idle and
// give no result. Requests are accepted while a result waits at the output.
// TABLE_DEPTH must be a power of two; the phase wraps over the table period.
// The tables have no reset and need no clearing pass.
module crossfading_wavetable_oscillator_top #(
    parameter int TABLE_DEPTH     = cwo_pkg::TABLE_DEPTH_DEF,
    parameter int SAMPLE_BITS     = cwo_pkg::SAMPLE_BITS_DEF,
    parameter int PHASE_FRAC_BITS = cwo_pkg::PHASE_FRAC_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                req_valid,
    output logic                                req_ready,
    input  cwo_pkg::req_t                       req,
    output logic                                rsp_valid,
    input  logic                                rsp_ready,
    output cwo_pkg::rsp_t                       rsp,
    input  logic                                cfg_we,
    input  logic [cwo_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  logic [cwo_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

    import cwo_pkg::*;

    `include "crossfading_wavetable_oscillator_top_macros.svh"

    localparam int IDXW = $clog2(TABLE_DEPTH);
    localparam int PW   = IDXW + PHASE_FRAC_BITS;
    localparam int SB   = SAMPLE_BITS;
    localparam int GW   = SB + REG16_BITS + 1;
    localparam logic signed [GW-1:0] GAIN_HALF = GW'(2 ** (GAIN_FRAC_BITS - 1));
    localparam logic signed [GW-1:0] SMAX = GW'((2 ** (SB - 1)) - 1);
    localparam logic signed [GW-1:0] SMIN = GW'(-(2 ** (SB - 1)));

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RB   = 3'd1;
    localparam logic [2:0] S_IP   = 3'd2;
    localparam logic [2:0] S_BL   = 3'd3;
    localparam logic [2:0] S_GN   = 3'd4;

    // configuration registers
    logic [STEP_BITS-1:0]  phase_step_reg;
    logic [REG16_BITS-1:0] volume_gain_reg;
    logic [REG16_BITS-1:0] fade_length_reg;
    logic [REG16_BITS-1:0] fade_step_reg;

    // control state
    logic [2:0]            state_reg, state_next;
    logic                  front_select_reg, front_select_next;
    logic                  front_valid_reg, front_valid_next;
    logic [PW-1:0]         phase_reg, phase_next;
    logic [REG16_BITS-1:0] fade_count_reg, fade_count_next;
    logic [REG16_BITS-1:0] fade_rem_reg, fade_rem_next;
    logic                  rsp_valid_reg, rsp_valid_next;

    // datapath registers
    logic signed [SB-1:0]    a0_reg, a0_next;
    logic signed [SB-1:0]    a1_reg, a1_next;
    logic [2*REG16_BITS-1:0] wprod_reg, wprod_next;
    logic [BLEND_BITS:0]     weight_reg, weight_next;
    logic signed [SB-1:0]    f_reg, f_next;
    logic signed [SB-1:0]    k_reg, k_next;
    logic signed [SB-1:0]    v_reg, v_next;
    rsp_t                    rsp_reg, rsp_next;

    // ram interface
    logic                  accept;
    logic                  we0, we1, idx_ok;
    logic [IDXW-1:0]       waddr, raddr;
    logic [SB-1:0]         wdata;
    logic [SB-1:0]         r0, r1;
    logic [PW-1:0]         phase_sum;
    logic                  fading;
    logic                  out_free;

    // arithmetic
    logic signed [SB-1:0]  fa, fb, ka, kb, f_lerp, k_lerp, blend;
    logic signed [GW-1:0]  gprod, gscaled;
    logic signed [SB-1:0]  gsat;

    // ------------------------------------------------------------------
    // configuration
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_step_reg  <= PHASE_STEP_RST;
            volume_gain_reg <= VOLUME_GAIN_RST;
            fade_length_reg <= FADE_LENGTH_RST;
            fade_step_reg   <= FADE_STEP_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_PHASE_STEP:  phase_step_reg  <= cfg_data[STEP_BITS-1:0];
                CFG_VOLUME_GAIN: volume_gain_reg <= cfg_data[REG16_BITS-1:0];
                CFG_FADE_LENGTH: fade_length_reg <= cfg_data[REG16_BITS-1:0];
                CFG_FADE_STEP:   fade_step_reg   <= cfg_data[REG16_BITS-1:0];
                default:         phase_step_reg  <= phase_step_reg;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // tables
    // ------------------------------------------------------------------
    assign req_ready = (state_reg == S_IDLE);
    assign accept    = req_valid && req_ready;
    assign idx_ok    = (32'(req.table_index) < TABLE_DEPTH);
    assign waddr     = IDXW'(req.table_index);
    assign wdata     = SB'(req.table_value);
    // the back table is the one not selected as front
    assign we0 = accept && (req.opcode == OP_WRITE) && idx_ok && front_select_reg;
    assign we1 = accept && (req.opcode == OP_WRITE) && idx_ok && !front_select_reg;

    assign phase_sum = phase_reg + PW'(phase_step_reg);
    // first read at the new phase while accepting, then its neighbor
    assign raddr = (state_reg == S_IDLE) ? phase_sum[PW-1 -: IDXW]
                                         : phase_reg[PW-1 -: IDXW] + IDXW'(1);

    cwo_ram #(
        .WIDTH (SB),
        .DEPTH (TABLE_DEPTH)
    ) u_table_zero (
        .clk   (clk),
        .we    (we0),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (r0)
    );

    cwo_ram #(
        .WIDTH (SB),
        .DEPTH (TABLE_DEPTH)
    ) u_table_one (
        .clk   (clk),
        .we    (we1),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (r1)
    );

    // ------------------------------------------------------------------
    // interpolation and blend
    // ------------------------------------------------------------------
    assign fa = front_select_reg ? a1_reg : a0_reg;
    assign fb = front_select_reg ? $signed(r1) : $signed(r0);
    assign ka = front_select_reg ? a0_reg : a1_reg;
    assign kb = front_select_reg ? $signed(r0) : $signed(r1);

    cwo_lerp #(
        .SAMPLE_BITS (SB),
        .WEIGHT_BITS (PHASE_FRAC_BITS)
    ) u_lerp_front (
        .a (fa),
        .b (fb),
        .w ({1'b0, phase_reg[PHASE_FRAC_BITS-1:0]}),
        .y (f_lerp)
    );

    cwo_lerp #(
        .SAMPLE_BITS (SB),
        .WEIGHT_BITS (PHASE_FRAC_BITS)
    ) u_lerp_back (
        .a (ka),
        .b (kb),
        .w ({1'b0, phase_reg[PHASE_FRAC_BITS-1:0]}),
        .y (k_lerp)
    );

    cwo_lerp #(
        .SAMPLE_BITS (SB),
        .WEIGHT_BITS (BLEND_BITS)
    ) u_lerp_blend (
        .a (f_reg),
        .b (k_reg),
        .w (weight_reg),
        .y (blend)
    );

    // gain and saturation
    always_comb
    begin
        gprod   = GW'(v_reg) * $signed({1'b0, volume_gain_reg});
        gscaled = (gprod + GAIN_HALF) >>> GAIN_FRAC_BITS;
        if (gscaled > SMAX)
        begin
            gsat = SB'(SMAX);
        end
        else if (gscaled < SMIN)
        begin
            gsat = SB'(SMIN);
        end
        else
        begin
            gsat = SB'(gscaled);
        end
    end

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    assign fading   = (fade_rem_reg != '0);
    assign out_free = !rsp_valid_reg || rsp_ready;

    always_comb
    begin
        state_next        = state_reg;
        front_select_next = front_select_reg;
        front_valid_next  = front_valid_reg;
        phase_next        = phase_reg;
        fade_count_next   = fade_count_reg;
        fade_rem_next     = fade_rem_reg;
        rsp_valid_next    = rsp_valid_reg && !rsp_ready;
        a0_next           = a0_reg;
        a1_next           = a1_reg;
        wprod_next        = wprod_reg;
        weight_next       = weight_reg;
        f_next            = f_reg;
        k_next            = k_reg;
        v_next            = v_reg;
        rsp_next          = rsp_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    priority if (req.opcode == OP_COMMIT)
                    begin
                        fade_count_next = '0;
                        fade_rem_next   = fade_length_reg;
                        if (fade_length_reg == '0)
                        begin
                            front_select_next = !front_select_reg;
                            front_valid_next  = 1'b1;
                        end
                    end
                    else if (req.opcode == OP_SAMPLE)
                    begin
                        phase_next = phase_sum;
                        state_next = S_RB;
                    end
                    else
                    begin
                        // writes go straight to the ram, no-op does nothing
                        state_next = S_IDLE;
                    end
                end
            end
            S_RB:
            begin
                a0_next    = $signed(r0);
                a1_next    = $signed(r1);
                wprod_next = fade_count_reg * fade_step_reg;
                state_next = S_IP;
            end
            S_IP:
            begin
                f_next      = front_valid_reg ? f_lerp : '0;
                k_next      = k_lerp;
                weight_next = (wprod_reg > 32'(BLEND_ONE)) ? BLEND_ONE
                                                          : wprod_reg[BLEND_BITS:0];
                state_next  = S_BL;
            end
            S_BL:
            begin
                v_next     = fading ? blend : f_reg;
                state_next = S_GN;
            end
            S_GN:
            begin
                if (out_free)
                begin
                    rsp_next.sample_out = OUT_BITS'(gsat);
                    rsp_next.fading     = fading;
                    rsp_valid_next      = 1'b1;
                    state_next          = S_IDLE;
                    if (fading)
                    begin
                        fade_count_next = fade_count_reg + 1'b1;
                        fade_rem_next   = fade_rem_reg - 1'b1;
                        // last crossfade sample, tables swap after it
                        if (fade_rem_reg == REG16_BITS'(1))
                        begin
                            front_select_next = !front_select_reg;
                            front_valid_next  = 1'b1;
                        end
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            front_select_reg <= 1'b0;
            front_valid_reg  <= 1'b0;
            phase_reg        <= '0;
            fade_count_reg   <= '0;
            fade_rem_reg     <= '0;
            rsp_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            front_select_reg <= front_select_next;
            front_valid_reg  <= front_valid_next;
            phase_reg        <= phase_next;
            fade_count_reg   <= fade_count_next;
            fade_rem_reg     <= fade_rem_next;
            rsp_valid_reg    <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a0_reg     <= a0_next;
        a1_reg     <= a1_next;
        wprod_reg  <= wprod_next;
        weight_reg <= weight_next;
        f_reg      <= f_next;
        k_reg      <= k_next;
        v_reg      <= v_next;
        rsp_reg    <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------
    `CWO_ASSERT(a_single_table_write, clk, rst_n, $onehot0({we0, we1}), "both tables written")
    `CWO_ASSERT_NEXT(a_result_loaded, clk, rst_n, (state_reg == S_GN) && out_free, rsp_valid_reg && (state_reg == S_IDLE), "finished sample not presented")
    `CWO_ASSERT(a_swap_validates, clk, rst_n, !$stable(front_select_reg) |-> front_valid_reg, "table swap left front invalid")
    `CWO_ASSERT(a_phase_on_sample, clk, rst_n, !$stable(phase_reg) |-> $past(accept && (req.opcode == OP_SAMPLE)), "phase moved without sample beat")

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// crossfading wavetable oscillator testbench
// drives write, commit, sample and no-op beats over valid/ready with random
// idling on both sides, predicts every sample beat in a scoreboard class and
// compares each result field by field, in order
// ----------------------------------------------------------------------------
import cwo_pkg::*;

class osc_scoreboard;
    localparam int     DEPTH      = TABLE_DEPTH_DEF;
    localparam int     FRAC       = PHASE_FRAC_BITS_DEF;
    localparam longint PHASE_UNIT = longint'(1) << FRAC;
    localparam longint BLEND_UNIT = longint'(1) << BLEND_BITS;
    localparam longint OUT_MAX    = (longint'(1) << (OUT_BITS - 1)) - 1;
    localparam longint OUT_MIN    = -(longint'(1) << (OUT_BITS - 1));

    logic signed [VALUE_BITS-1:0] wave [2][DEPTH];
    bit                           front_sel;
    bit                           front_ok;
    logic [STEP_BITS-1:0]         phase;
    logic [REG16_BITS-1:0]        fade_count;
    logic [REG16_BITS-1:0]        fade_left;
    logic [STEP_BITS-1:0]         step_reg;
    logic [REG16_BITS-1:0]        gain_reg;
    logic [REG16_BITS-1:0]        len_reg;
    logic [REG16_BITS-1:0]        fstep_reg;
    rsp_t                         expected_q[$];
    int                           errors;
    int                           results;

    function new();
        front_sel  = 1'b0;
        front_ok   = 1'b0;
        phase      = '0;
        fade_count = '0;
        fade_left  = '0;
        step_reg   = PHASE_STEP_RST;
        gain_reg   = VOLUME_GAIN_RST;
        len_reg    = FADE_LENGTH_RST;
        fstep_reg  = FADE_STEP_RST;
        errors     = 0;
        results    = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_BITS-1:0] which, logic [CFG_DATA_BITS-1:0] value);
        case (which)
            CFG_PHASE_STEP:  step_reg  = value[STEP_BITS-1:0];
            CFG_VOLUME_GAIN: gain_reg  = value[REG16_BITS-1:0];
            CFG_FADE_LENGTH: len_reg   = value[REG16_BITS-1:0];
            CFG_FADE_STEP:   fstep_reg = value[REG16_BITS-1:0];
            default: ;
        endcase
    endfunction

    // linear interpolation between an entry and the next, last wraps to first
    function longint interp(bit sel, logic [STEP_BITS-1:0] ph);
        logic [INDEX_BITS-1:0] idx;
        logic [INDEX_BITS-1:0] nxt;
        longint                a;
        longint                b;
        longint                f;
        idx = ph[STEP_BITS-1:FRAC];
        nxt = idx + 1'b1;
        a   = wave[sel][idx];
        b   = wave[sel][nxt];
        f   = ph[FRAC-1:0];
        return (a * (PHASE_UNIT - f) + b * f + PHASE_UNIT / 2) >>> FRAC;
    endfunction

    function void swap_tables();
        front_sel = !front_sel;
        front_ok  = 1'b1;
    endfunction

    function void note_request(req_t beat);
        longint near_v;
        longint far_v;
        longint mix;
        longint weight;
        longint scaled;
        rsp_t   want;
        case (beat.opcode)
            OP_WRITE: wave[!front_sel][beat.table_index] = beat.table_value;
            OP_COMMIT:
            begin
                fade_count = '0;
                fade_left  = len_reg;
                if (fade_left == 0)
                    swap_tables();
            end
            OP_SAMPLE:
            begin
                // phase is 27 bits wide, so the add wraps over the table period
                phase       = phase + step_reg;
                near_v      = front_ok ? interp(front_sel, phase) : 0;
                mix         = near_v;
                want.fading = 1'b0;
                if (fade_left != 0)
                begin
                    far_v  = interp(!front_sel, phase);
                    weight = longint'(fade_count) * longint'(fstep_reg);
                    if (weight > BLEND_UNIT)
                        weight = BLEND_UNIT;
                    mix = (near_v * (BLEND_UNIT - weight) + far_v * weight + BLEND_UNIT / 2)
                          >>> BLEND_BITS;
                    fade_count++;
                    fade_left--;
                    want.fading = 1'b1;
                    // last fading sample still uses the old roles
                    if (fade_left == 0)
                        swap_tables();
                end
                scaled = (mix * longint'(gain_reg) + (longint'(1) << (GAIN_FRAC_BITS - 1)))
                         >>> GAIN_FRAC_BITS;
                if (scaled > OUT_MAX)
                    scaled = OUT_MAX;
                else if (scaled < OUT_MIN)
                    scaled = OUT_MIN;
                want.sample_out = scaled[OUT_BITS-1:0];
                expected_q.push_back(want);
            end
            default: ;
        endcase
    endfunction

    task report(string what);
        if (errors < 40)
            $display("ERROR: %s", what);
        errors++;
    endtask

    task check_sample(rsp_t got);
        rsp_t want;
        results++;
        if (expected_q.size() == 0)
        begin
            report($sformatf("result %0d arrived with no sample pending", results));
            return;
        end
        want = expected_q.pop_front();
        if (got.sample_out !== want.sample_out)
            report($sformatf("result %0d sample_out %0d, expected %0d",
                             results, got.sample_out, want.sample_out));
        if (got.fading !== want.fading)
            report($sformatf("result %0d fading %0b, expected %0b",
                             results, got.fading, want.fading));
    endtask
endclass

module testbench;
    localparam int CLK_HALF      = 2;
    localparam int RESET_CYCLES  = 5;
    localparam int SETTLE_CYCLES = 8;
    localparam int PHASES        = 7;
    localparam int PHASE_ITEMS   = 80;
    localparam int STEADY_PHASE  = 3;
    localparam int TIMEOUT_NS    = 4000000;

    logic                     clk       = 1'b0;
    logic                     rst_n     = 1'b0;
    logic                     req_valid = 1'b0;
    logic                     req_ready;
    req_t                     req       = '0;
    logic                     rsp_valid;
    logic                     rsp_ready = 1'b0;
    rsp_t                     rsp;
    logic                     cfg_we    = 1'b0;
    logic [CFG_IDX_BITS-1:0]  cfg_index = CFG_PHASE_STEP;
    logic [CFG_DATA_BITS-1:0] cfg_data  = '0;
    bit                       steady    = 1'b0;
    osc_scoreboard            sb        = new();

    crossfading_wavetable_oscillator_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #(CLK_HALF) clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n)
            rsp_ready <= steady || ($urandom_range(0, 99) >= 33);
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && rsp_ready)
            sb.check_sample(rsp);
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("crossfading_wavetable_oscillator_top: mismatch");
        $finish;
    end

    task automatic send_beat(input req_t beat);
        req       <= beat;
        req_valid <= 1'b1;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        sb.note_request(beat);
        if (!steady && $urandom_range(0, 99) < 33)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 8))
                @(posedge clk);
        end
    endtask

    function automatic req_t random_beat();
        req_t        beat;
        logic [31:0] rnd;
        int          pick;
        rnd               = $urandom;
        pick              = $urandom_range(0, 99);
        beat.table_index  = rnd[INDEX_BITS-1:0];
        beat.table_value  = rnd[31:16];
        if (pick < 55)
            beat.opcode = OP_SAMPLE;
        else if (pick < 85)
            beat.opcode = OP_WRITE;
        else if (pick < 93)
            beat.opcode = OP_COMMIT;
        else
            beat.opcode = OP_NOP;
        if (pick % 10 == 0)
            beat.table_value = 16'h7fff;
        else if (pick % 10 == 1)
            beat.table_value = 16'h8000;
        return beat;
    endfunction

    task automatic send_op(input logic [OPCODE_BITS-1:0] op);
        req_t beat;
        beat        = random_beat();
        beat.opcode = op;
        send_beat(beat);
    endtask

    // every entry of the back table, extremes next to each other now and then
    task automatic fill_back_table();
        req_t        beat;
        logic [31:0] rnd;
        for (int i = 0; i < TABLE_DEPTH_DEF; i++)
        begin
            rnd              = $urandom;
            beat.opcode      = OP_WRITE;
            beat.table_index = i[INDEX_BITS-1:0];
            case (i % 8)
                0:       beat.table_value = 16'h7fff;
                1:       beat.table_value = 16'h8000;
                default: beat.table_value = rnd[15:0];
            endcase
            send_beat(beat);
        end
    endtask

    task automatic drain();
        req_valid <= 1'b0;
        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    task automatic put_reg(input logic [CFG_IDX_BITS-1:0] which,
                           input logic [CFG_DATA_BITS-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= which;
        cfg_data  <= value;
        @(posedge clk);
        sb.set_reg(which, value);
    endtask

    task automatic write_regs(input logic [STEP_BITS-1:0] step,
                              input logic [REG16_BITS-1:0] gain,
                              input logic [REG16_BITS-1:0] len,
                              input logic [REG16_BITS-1:0] fstep);
        drain();
        put_reg(CFG_PHASE_STEP, CFG_DATA_BITS'(step));
        put_reg(CFG_VOLUME_GAIN, CFG_DATA_BITS'(gain));
        put_reg(CFG_FADE_LENGTH, CFG_DATA_BITS'(len));
        put_reg(CFG_FADE_STEP, CFG_DATA_BITS'(fstep));
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        req_t                  beat;
        logic [STEP_BITS-1:0]  step_v;
        logic [STEP_BITS-1:0]  nxt_ph;
        logic [REG16_BITS-1:0] gain_v;
        logic [REG16_BITS-1:0] len_v;
        logic [REG16_BITS-1:0] fstep_v;
        logic [31:0]           rnd;

        repeat (RESET_CYCLES)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_regs(27'h0014000, VOLUME_GAIN_RST, 16'd4, 16'd16384);
        // front table not valid yet, samples read as silence
        send_op(OP_SAMPLE);
        send_op(OP_NOP);
        send_op(OP_SAMPLE);

        fill_back_table();
        // fade in from silence, swap follows the fourth sample
        send_op(OP_COMMIT);
        repeat (5)
            send_op(OP_SAMPLE);

        fill_back_table();
        send_op(OP_COMMIT);
        repeat (2)
            send_op(OP_SAMPLE);
        // restart mid-fade, then hit the entry the next sample reads
        send_op(OP_COMMIT);
        nxt_ph           = sb.phase + sb.step_reg;
        beat.opcode      = OP_WRITE;
        beat.table_index = nxt_ph[STEP_BITS-1:PHASE_FRAC_BITS_DEF];
        beat.table_value = 16'h7fff;
        send_beat(beat);
        repeat (5)
            send_op(OP_SAMPLE);

        // zero-length fade swaps immediately; max gain saturates
        write_regs('1, '1, '0, '1);
        send_op(OP_COMMIT);
        repeat (2)
            send_op(OP_SAMPLE);

        for (int p = 0; p < PHASES; p++)
        begin
            rnd = $urandom;
            case (p)
                0:
                begin
                    step_v  = '0;
                    gain_v  = VOLUME_GAIN_RST;
                    len_v   = 16'd3;
                    fstep_v = 16'd21845;
                end
                1:
                begin
                    step_v  = '1;
                    gain_v  = '1;
                    len_v   = 16'd1;
                    fstep_v = '1;
                end
                2:
                begin
                    step_v  = STEP_BITS'($urandom_range(0, 1 << 18));
                    gain_v  = '0;
                    len_v   = '0;
                    fstep_v = '0;
                end
                STEADY_PHASE:
                begin
                    step_v  = rnd[STEP_BITS-1:0];
                    gain_v  = REG16_BITS'($urandom_range(0, 65535));
                    len_v   = REG16_BITS'($urandom_range(2, 12));
                    fstep_v = REG16_BITS'(BLEND_ONE / len_v);
                end
                4:
                begin
                    step_v  = STEP_BITS'(1 << PHASE_FRAC_BITS_DEF);
                    gain_v  = REG16_BITS'($urandom_range(0, 8192));
                    len_v   = '1;
                    fstep_v = rnd[REG16_BITS-1:0];
                end
                5:
                begin
                    step_v  = rnd[STEP_BITS-1:0];
                    gain_v  = VOLUME_GAIN_RST;
                    len_v   = FADE_LENGTH_RST;
                    fstep_v = FADE_STEP_RST;
                end
                default:
                begin
                    step_v  = rnd[STEP_BITS-1:0];
                    gain_v  = REG16_BITS'($urandom_range(0, 65535));
                    len_v   = REG16_BITS'($urandom_range(1, 8));
                    fstep_v = REG16_BITS'($urandom_range(0, 65535));
                end
            endcase
            write_regs(step_v, gain_v, len_v, fstep_v);
            steady <= (p == STEADY_PHASE);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                // let the pipeline run dry once mid-stream
                if (p == PHASES - 1 && n == PHASE_ITEMS / 2)
                    drain();
                send_beat(random_beat());
            end
        end

        drain();
        repeat (SETTLE_CYCLES * 2)
            @(posedge clk);
        if (sb.errors == 0 && sb.expected_q.size() == 0)
            $display("crossfading_wavetable_oscillator_top: match");
        else
            $display("crossfading_wavetable_oscillator_top: mismatch");
        $finish;
    end
endmodule
